FILE: rtl/multi_server_rr_fcfs_dispatcher_top_defines.svh
// assertion macros for the dispatcher checker
`ifndef MULTI_SERVER_RR_FCFS_DISPATCHER_TOP_DEFINES_SVH
`define MULTI_SERVER_RR_FCFS_DISPATCHER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSRFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dispatcher check failed");

// next-cycle implication, sampled on clk, off during reset
`define MSRFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dispatcher check failed");

`endif

FILE: rtl/msrfd_pkg.sv
// shared types and constants of the job dispatcher
package msrfd_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_DROP   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic MODE_RR   = 1'b0;
  localparam logic MODE_FCFS = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_WORKERS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLICE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ARR  = 6'b000010,
    ST_RD   = 6'b000100,
    ST_ASGN = 6'b001000,
    ST_DEC  = 6'b010000,
    ST_REP  = 6'b100000
  } state_t;

endpackage

FILE: rtl/multi_server_rr_fcfs_dispatcher_top.sv
// job dispatcher: one fifo of waiting jobs feeding several workers, round robin or fcfs
// arrival: result registered once the output register is free; input ready again as it turns valid
// tick with n active workers: per worker a fifo head read and a take, then per worker a pass
// through the shared decrement unit, then one report per worker
// results wait in an output register; a tick gives n reports, an arrival one result
// rst is synchronous: fifo empty, all workers free, config registers at defaults; fifo ram kept
module multi_server_rr_fcfs_dispatcher_top #(
  parameter int MAX_WORKERS = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // job_id, job_weight, job_quantity
  input  logic [msrfd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // req_type
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // worker_index, worker_busy, held_job, time_left, all_idle, zero pad
  output logic [msrfd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // report_kind
  output logic [1:0]                             m_axis_tuser,
  // last_of_run
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [msrfd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [msrfd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int WIDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CMP_W  = WIDX_W + 5;
  localparam int QA_W   = $clog2(QUEUE_DEPTH);
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

  msrfd_pkg::state_t state;

  logic [3:0]        workers_in_use;
  logic [15:0]       slice_length;
  logic              schedule_mode;

  logic [WIDX_W-1:0] widx;
  logic [QA_W-1:0]   queue_head;
  logic [QC_W-1:0]   queue_count;

  logic [15:0]       worker_job       [MAX_WORKERS];
  logic [15:0]       worker_remaining [MAX_WORKERS];
  logic [15:0]       worker_slice     [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] busy_flag;

  logic [15:0]       wait_ids   [QUEUE_DEPTH];
  logic [15:0]       wait_times [QUEUE_DEPTH];
  logic [15:0]       rd_id;
  logic [15:0]       rd_time;

  logic [15:0]       arr_id;
  logic [15:0]       arr_time;

  logic              rep_busy [MAX_WORKERS];
  logic [15:0]       rep_job  [MAX_WORKERS];
  logic [15:0]       rep_time [MAX_WORKERS];

  logic              out_valid;
  logic [1:0]        out_kind;
  logic [2:0]        out_idx;
  logic              out_busy;
  logic [15:0]       out_job;
  logic [15:0]       out_time;
  logic              out_idle;
  logic              out_last;

  logic              s_acc;
  logic              out_free;
  logic              out_load;
  logic [CMP_W-1:0]  n_eff;
  logic [CMP_W-1:0]  widx_c;
  logic              widx_last;
  logic [15:0]       slice_eff;
  logic              q_full;
  logic [QC_W:0]     tail_sum;
  logic [QA_W-1:0]   tail;
  logic [QA_W-1:0]   head_inc;
  logic [15:0]       cur_rem;
  logic [15:0]       cur_job;
  logic [15:0]       cur_slice;
  logic              cur_busy;
  logic [15:0]       rem_dec;
  logic [15:0]       slice_inc;
  logic              slice_hit;
  logic              dec_requeue;
  logic              take;
  logic              push_en;
  logic [15:0]       push_id;
  logic [15:0]       push_time;
  logic              all_idle_now;

  assign s_axis_tready = (state == msrfd_pkg::ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign out_load      = ((state == msrfd_pkg::ST_ARR) || (state == msrfd_pkg::ST_REP)) &&
                         out_free;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {3'b000, out_idle, out_time, out_job, out_busy, out_idx};

  always_comb begin
    if (workers_in_use == 4'd0) begin
      n_eff = CMP_W'(1);
    end else if (CMP_W'(workers_in_use) > CMP_W'(MAX_WORKERS)) begin
      n_eff = CMP_W'(MAX_WORKERS);
    end else begin
      n_eff = CMP_W'(workers_in_use);
    end
  end

  assign widx_c    = CMP_W'(widx);
  assign widx_last = (widx_c == n_eff - CMP_W'(1));
  assign slice_eff = (slice_length == 16'd0) ? 16'd1 : slice_length;

  assign q_full   = (queue_count == QC_W'(QUEUE_DEPTH));
  assign tail_sum = (QC_W+1)'(queue_head) + (QC_W+1)'(queue_count);
  assign tail     = (tail_sum >= (QC_W+1)'(QUEUE_DEPTH)) ?
                    QA_W'(tail_sum - (QC_W+1)'(QUEUE_DEPTH)) : QA_W'(tail_sum);
  assign head_inc = (queue_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : queue_head + QA_W'(1);

  // shared decrement and slice step for the worker under the pointer
  assign cur_rem     = worker_remaining[widx];
  assign cur_job     = worker_job[widx];
  assign cur_slice   = worker_slice[widx];
  assign cur_busy    = busy_flag[widx];
  assign rem_dec     = cur_rem - 16'd1;
  assign slice_inc   = cur_slice + 16'd1;
  assign slice_hit   = (slice_inc >= slice_eff);
  assign dec_requeue = cur_busy && (rem_dec != 16'd0) &&
                       (schedule_mode == msrfd_pkg::MODE_RR) && slice_hit;

  assign take = (state == msrfd_pkg::ST_ASGN) && !cur_busy && (queue_count != '0);

  always_comb begin
    push_en   = 1'b0;
    push_id   = cur_job;
    push_time = rem_dec;
    case (state)
      msrfd_pkg::ST_ARR: begin
        push_en   = out_free && !q_full;
        push_id   = arr_id;
        push_time = arr_time;
      end
      msrfd_pkg::ST_DEC: begin
        push_en = dec_requeue && !q_full;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  assign all_idle_now = (queue_count == '0) && !(|busy_flag);

  // fifo ram
  always_ff @(posedge clk) begin
    if (push_en) begin
      wait_ids[tail]   <= push_id;
      wait_times[tail] <= push_time;
    end
    rd_id   <= wait_ids[queue_head];
    rd_time <= wait_times[queue_head];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= msrfd_pkg::ST_IDLE;
      workers_in_use <= 4'd1;
      slice_length   <= 16'd1;
      schedule_mode  <= msrfd_pkg::MODE_RR;
      widx           <= '0;
      queue_head     <= '0;
      queue_count    <= '0;
      busy_flag      <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        worker_job[i]       <= 16'd0;
        worker_remaining[i] <= 16'd0;
        worker_slice[i]     <= 16'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          msrfd_pkg::CFG_WORKERS: workers_in_use <= cfg_data[3:0];
          msrfd_pkg::CFG_SLICE:   slice_length   <= cfg_data;
          msrfd_pkg::CFG_MODE:    schedule_mode  <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      if (push_en) begin
        queue_count <= queue_count + QC_W'(1);
      end

      case (state)
        msrfd_pkg::ST_IDLE: begin
          if (s_acc) begin
            widx <= '0;
            if (s_axis_tuser == msrfd_pkg::REQ_TICK) begin
              state <= msrfd_pkg::ST_RD;
            end else begin
              state <= msrfd_pkg::ST_ARR;
            end
          end
        end
        msrfd_pkg::ST_ARR: begin
          if (out_free) begin
            state <= msrfd_pkg::ST_IDLE;
          end
        end
        msrfd_pkg::ST_RD: begin
          state <= msrfd_pkg::ST_ASGN;
        end
        msrfd_pkg::ST_ASGN: begin
          if (take) begin
            worker_job[widx]       <= rd_id;
            worker_remaining[widx] <= rd_time;
            worker_slice[widx]     <= 16'd0;
            busy_flag[widx]        <= (rd_time != 16'd0);
            queue_head             <= head_inc;
            queue_count            <= queue_count - QC_W'(1);
          end
          if (widx_last) begin
            widx  <= '0;
            state <= msrfd_pkg::ST_DEC;
          end else begin
            widx  <= widx + WIDX_W'(1);
            state <= msrfd_pkg::ST_RD;
          end
        end
        msrfd_pkg::ST_DEC: begin
          if (cur_busy) begin
            if (rem_dec == 16'd0) begin
              worker_remaining[widx] <= 16'd0;
              worker_slice[widx]     <= 16'd0;
              busy_flag[widx]        <= 1'b0;
            end else if (schedule_mode == msrfd_pkg::MODE_RR) begin
              if (slice_hit) begin
                worker_slice[widx] <= 16'd0;
                if (!q_full) begin
                  worker_remaining[widx] <= 16'd0;
                  worker_job[widx]       <= 16'd0;
                  busy_flag[widx]        <= 1'b0;
                end else begin
                  worker_remaining[widx] <= rem_dec;
                end
              end else begin
                worker_slice[widx]     <= slice_inc;
                worker_remaining[widx] <= rem_dec;
              end
            end else begin
              worker_remaining[widx] <= rem_dec;
            end
          end
          if (widx_last) begin
            widx  <= '0;
            state <= msrfd_pkg::ST_REP;
          end else begin
            widx <= widx + WIDX_W'(1);
          end
        end
        msrfd_pkg::ST_REP: begin
          if (out_free) begin
            if (widx_last) begin
              widx  <= '0;
              state <= msrfd_pkg::ST_IDLE;
            end else begin
              widx <= widx + WIDX_W'(1);
            end
          end
        end
        default: begin
          state <= msrfd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      msrfd_pkg::ST_IDLE: begin
        if (s_acc) begin
          arr_id   <= s_axis_tdata[15:0];
          arr_time <= 16'(s_axis_tdata[23:16]) * 16'(s_axis_tdata[31:24]);
        end
      end
      msrfd_pkg::ST_ARR: begin
        if (out_free) begin
          out_kind <= q_full ? msrfd_pkg::KIND_DROP : msrfd_pkg::KIND_ACCEPT;
          out_idx  <= 3'd0;
          out_busy <= 1'b0;
          out_job  <= arr_id;
          out_time <= arr_time;
          // fifo holds at least one job after an arrival
          out_idle <= 1'b0;
          out_last <= 1'b1;
        end
      end
      msrfd_pkg::ST_DEC: begin
        rep_busy[widx] <= cur_busy;
        rep_job[widx]  <= cur_busy ? cur_job : 16'd0;
        rep_time[widx] <= cur_rem;
      end
      msrfd_pkg::ST_REP: begin
        if (out_free) begin
          out_kind <= msrfd_pkg::KIND_REPORT;
          out_idx  <= 3'(widx);
          out_busy <= rep_busy[widx];
          out_job  <= rep_job[widx];
          out_time <= rep_time[widx];
          out_idle <= all_idle_now;
          out_last <= widx_last;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/msrfd_checker.sv
// port-level checks of the job dispatcher and their bind
`include "multi_server_rr_fcfs_dispatcher_top_defines.svh"

module msrfd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [msrfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                        m_axis_tuser,
  input logic                              m_axis_tlast
);

  `MSRFD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `MSRFD_ASSERT_IMP(a_kind_legal, m_axis_tvalid, m_axis_tuser != 2'd3)
  `MSRFD_ASSERT_IMP(a_arrival_last, m_axis_tvalid && m_axis_tuser != msrfd_pkg::KIND_REPORT, m_axis_tlast)
  `MSRFD_ASSERT_IMP(a_arrival_no_worker, m_axis_tvalid && m_axis_tuser != msrfd_pkg::KIND_REPORT, m_axis_tdata[3:0] == 4'd0)
  `MSRFD_ASSERT_IMP(a_free_report_empty, m_axis_tvalid && m_axis_tuser == msrfd_pkg::KIND_REPORT && !m_axis_tdata[3], m_axis_tdata[35:4] == 32'd0)

endmodule

bind multi_server_rr_fcfs_dispatcher_top msrfd_checker u_msrfd_checker (.*);

FILE: verif/tb_top.sv
// self-checking testbench for the job dispatcher: directed table, then random phases
`timescale 1ns / 1ps

module tb_top;
  import msrfd_pkg::*;

  localparam int NWORK = 8;
  localparam int QDEPTH = 64;
  localparam int LIMIT_CYCLES = 1000000;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  idx;
    logic        busy;
    logic [15:0] job;
    logic [15:0] tl;
    logic        idle;
    logic        last;
  } report_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] sel;
    logic [CFG_DATA_W-1:0]  val;
    logic                   req;
    logic [15:0]            id;
    logic [7:0]             w;
    logic [7:0]             q;
    bit                     typed;
    report_t                want;
  } step_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // dispatcher state as predicted
  logic [15:0] q_ids [QDEPTH];
  logic [15:0] q_times [QDEPTH];
  int          q_head;
  int          q_count;
  logic [15:0] w_job [NWORK];
  logic [15:0] w_left [NWORK];
  logic [15:0] w_slice [NWORK];
  logic [3:0]  cfg_workers;
  logic [15:0] cfg_slice;
  logic        cfg_mode;

  report_t expected_reports[$];
  step_t   plan[$];
  int      errors;
  int      cycles;
  bit      tx_quiet;
  bit      rx_quiet;

  multi_server_rr_fcfs_dispatcher_top #(
    .MAX_WORKERS(NWORK),
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void add_expected(report_t r);
    expected_reports = {expected_reports, r};
  endfunction

  function automatic void add_step(step_t s);
    plan = {plan, s};
  endfunction

  function automatic bit queue_push(logic [15:0] id, logic [15:0] t);
    int pos;
    if (q_count >= QDEPTH) return 1'b0;
    pos = (q_head + q_count) % QDEPTH;
    q_ids[pos] = id;
    q_times[pos] = t;
    q_count++;
    return 1'b1;
  endfunction

  function automatic logic all_idle();
    if (q_count != 0) return 1'b0;
    for (int i = 0; i < NWORK; i++)
      if (w_left[i] != 0) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_reports(input logic rt, input logic [15:0] id,
                                 input logic [7:0] w, input logic [7:0] q);
    report_t     rep [NWORK];
    int          n;
    int          sl;
    logic [15:0] t;
    bit          ok;
    bit          busy;
    logic        idle;
    if (rt == REQ_ARRIVAL) begin
      t = 16'(w) * 16'(q);
      ok = queue_push(id, t);
      add_expected(report_t'{ok ? KIND_ACCEPT : KIND_DROP, 3'd0, 1'b0, id, t,
                             all_idle(), 1'b1});
    end else begin
      n = (cfg_workers == 0) ? 1 : ((cfg_workers > NWORK) ? NWORK : int'(cfg_workers));
      sl = (cfg_slice == 0) ? 1 : int'(cfg_slice);
      for (int i = 0; i < n; i++) begin
        if (w_left[i] == 0 && q_count > 0) begin
          w_job[i] = q_ids[q_head];
          w_left[i] = q_times[q_head];
          w_slice[i] = 16'd0;
          q_head = (q_head + 1) % QDEPTH;
          q_count--;
        end
      end
      for (int i = 0; i < n; i++) begin
        busy = (w_left[i] != 0);
        rep[i] = report_t'{KIND_REPORT, 3'(i), busy, busy ? w_job[i] : 16'd0, w_left[i],
                           1'b0, 1'b0};
      end
      for (int i = 0; i < n; i++) begin
        if (w_left[i] == 0) continue;
        w_left[i] = w_left[i] - 16'd1;
        if (w_left[i] == 0) begin
          w_slice[i] = 16'd0;
          continue;
        end
        if (cfg_mode == MODE_RR) begin
          w_slice[i] = w_slice[i] + 16'd1;
          if (int'(w_slice[i]) >= sl) begin
            w_slice[i] = 16'd0;
            if (queue_push(w_job[i], w_left[i])) begin
              w_left[i] = 16'd0;
              w_job[i] = 16'd0;
            end
          end
        end
      end
      idle = all_idle();
      for (int i = 0; i < n; i++) begin
        rep[i].idle = idle;
        rep[i].last = (i == n - 1);
        add_expected(rep[i]);
      end
    end
  endtask

  task automatic send_request(input logic rt, input logic [15:0] id,
                              input logic [7:0] w, input logic [7:0] q);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {q, w, id};
    s_axis_tuser <= rt;
    do @(posedge clk); while (!s_axis_tready);
    predict_reports(rt, id, w, q);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val,
                           input bit hold);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      CFG_WORKERS: cfg_workers = val[3:0];
      CFG_SLICE:   cfg_slice = val;
      CFG_MODE:    cfg_mode = val[0];
      default: ;
    endcase
    if (!hold) cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int workers, input int slice_len, input logic mode);
    write_reg(CFG_WORKERS, 16'(workers), 1'b1);
    write_reg(CFG_SLICE, 16'(slice_len), 1'b1);
    write_reg(CFG_MODE, 16'(mode), 1'b0);
  endtask

  function automatic step_t item_step(logic rt, logic [15:0] id, logic [7:0] w, logic [7:0] q,
                                      bit typed = 1'b0, report_t want = '0);
    step_t s;
    s = '{default: '0};
    s.req = rt;
    s.id = id;
    s.w = w;
    s.q = q;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic step_t cfg_step(logic [CFG_INDEX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.sel = sel;
    s.val = val;
    return s;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected item expected none actual kind %h tdata %h last %b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_reports.pop_front();
        check_field("report_kind", 16'(want.kind), 16'(m_axis_tuser));
        check_field("worker_index", 16'(want.idx), 16'(m_axis_tdata[2:0]));
        check_field("worker_busy", 16'(want.busy), 16'(m_axis_tdata[3]));
        check_field("held_job", want.job, m_axis_tdata[19:4]);
        check_field("time_left", want.tl, m_axis_tdata[35:20]);
        check_field("all_idle", 16'(want.idle), 16'(m_axis_tdata[36]));
        check_field("last_of_run", 16'(want.last), 16'(m_axis_tlast));
      end
    end
  end

  initial begin
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    int          phase_items [8];
    int          phase_pct [8];
    logic        rt;
    logic [15:0] id;
    logic [7:0]  w;
    logic [7:0]  q;
    int          r;

    phase_items = '{50, 50, 90, 50, 50, 40, 60, 60};
    phase_pct = '{50, 55, 85, 25, 50, 50, 60, 45};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    q_head = 0;
    q_count = 0;
    for (int i = 0; i < QDEPTH; i++) begin
      q_ids[i] = '0;
      q_times[i] = '0;
    end
    for (int i = 0; i < NWORK; i++) begin
      w_job[i] = '0;
      w_left[i] = '0;
      w_slice[i] = '0;
    end
    cfg_workers = 4'd1;
    cfg_slice = 16'd1;
    cfg_mode = MODE_RR;

    // reset settings: one worker, slice of one, round robin
    add_step(item_step(REQ_TICK, 16'h0000, 8'h00, 8'h00, 1'b1,
                       report_t'{KIND_REPORT, 3'd0, 1'b0, 16'h0, 16'h0, 1'b1, 1'b1}));
    add_step(item_step(REQ_ARRIVAL, 16'hFFFF, 8'hFF, 8'h01, 1'b1,
                       report_t'{KIND_ACCEPT, 3'd0, 1'b0, 16'hFFFF, 16'd255, 1'b0, 1'b1}));
    add_step(item_step(REQ_ARRIVAL, 16'h0000, 8'h00, 8'h00, 1'b1,
                       report_t'{KIND_ACCEPT, 3'd0, 1'b0, 16'h0000, 16'd0, 1'b0, 1'b1}));
    add_step(item_step(REQ_ARRIVAL, 16'h1234, 8'h01, 8'hFF, 1'b1,
                       report_t'{KIND_ACCEPT, 3'd0, 1'b0, 16'h1234, 16'd255, 1'b0, 1'b1}));
    add_step(item_step(REQ_ARRIVAL, 16'h00AA, 8'h02, 8'h03, 1'b1,
                       report_t'{KIND_ACCEPT, 3'd0, 1'b0, 16'h00AA, 16'd6, 1'b0, 1'b1}));
    add_step(item_step(REQ_TICK, 16'hFFFF, 8'hFF, 8'hFF));
    add_step(item_step(REQ_TICK, 16'h0000, 8'h00, 8'h00));
    add_step(item_step(REQ_TICK, 16'h5555, 8'h55, 8'hAA));
    add_step(cfg_step(CFG_MODE, 16'(MODE_FCFS)));
    add_step(cfg_step(CFG_WORKERS, 16'd0));
    add_step(item_step(REQ_TICK, 16'h0001, 8'h00, 8'h00));
    add_step(cfg_step(CFG_WORKERS, 16'd15));
    add_step(item_step(REQ_TICK, 16'h0002, 8'h00, 8'h00));
    add_step(item_step(REQ_TICK, 16'h0003, 8'h00, 8'h00));
    add_step(cfg_step(CFG_SLICE, 16'd0));
    add_step(cfg_step(CFG_MODE, 16'(MODE_RR)));
    add_step(item_step(REQ_TICK, 16'h0004, 8'h00, 8'h00));
    add_step(item_step(REQ_TICK, 16'h0005, 8'h00, 8'h00));
    add_step(cfg_step(CFG_WORKERS, 16'd2));
    add_step(cfg_step(CFG_SLICE, 16'd3));
    add_step(item_step(REQ_ARRIVAL, 16'h5A5A, 8'h07, 8'h09));
    add_step(item_step(REQ_ARRIVAL, 16'hA5A5, 8'hFF, 8'h00, 1'b1,
                       report_t'{KIND_ACCEPT, 3'd0, 1'b0, 16'hA5A5, 16'd0, 1'b0, 1'b1}));
    for (int i = 0; i < 4; i++) add_step(item_step(REQ_TICK, 16'(i), 8'h00, 8'h00));
    add_step(cfg_step(CFG_UNUSED, 16'hFFFF));
    add_step(item_step(REQ_TICK, 16'h0000, 8'h00, 8'h00));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].sel, plan[i].val, (i + 1 < plan.size()) && plan[i + 1].is_cfg);
      end else begin
        send_request(plan[i].req, plan[i].id, plan[i].w, plan[i].q);
        if (plan[i].typed) begin
          void'(expected_reports.pop_back());
          add_expected(plan[i].want);
        end
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(1, 1, MODE_RR);
        1: set_config(8, 65535, MODE_FCFS);
        2: set_config(3, 2, MODE_RR);
        3: wait_drained();
        4: set_config(15, 0, MODE_RR);
        5: set_config(0, $urandom_range(1, 65535), MODE_FCFS);
        6: set_config($urandom_range(1, 8), $urandom_range(1, 4), MODE_RR);
        default: set_config(8, 1, MODE_RR);
      endcase
      tx_quiet = (p == 1) || (p == 6);
      rx_quiet = (p == 1) || (p == 4);
      for (int k = 0; k < phase_items[p]; k++) begin
        rt = ($urandom_range(0, 99) < phase_pct[p]) ? REQ_ARRIVAL : REQ_TICK;
        id = 16'($urandom);
        r = $urandom_range(0, 9);
        if (rt == REQ_TICK || (q_count >= QDEPTH && r < 5)) begin
          w = 8'($urandom_range(0, 255));
          q = 8'($urandom_range(0, 255));
        end else if (r == 9) begin
          w = 8'($urandom_range(0, 15));
          q = 8'($urandom_range(0, 15));
        end else begin
          w = 8'($urandom_range(0, 4));
          q = 8'($urandom_range(0, 5));
        end
        send_request(rt, id, w, q);
      end
    end

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_drained();
    repeat (4 * NWORK + 20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
